>>> design/pps_pkg.sv
// shared constants, types and codes for the preemptive priority scheduler
`timescale 1ns / 1ps

package pps_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_ADMIT = 1'b1;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  slot_cnt_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] remaining;
    } slot_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  job_id;
        logic [7:0]  job_priority;
        logic [15:0] job_arrival;
        logic [15:0] job_burst;
    } item_t;

    typedef struct packed {
        logic        admit_ok;
        logic        busy_res;
        logic [7:0]  running_id;
        logic        finished;
        logic [15:0] finish_time;
    } res_t;

endpackage

>>> design/pps_if.sv
// valid/ready channel interfaces for job beats and result beats
`timescale 1ns / 1ps

interface pps_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  job_id;
    logic [7:0]  job_priority;
    logic [15:0] job_arrival;
    logic [15:0] job_burst;

    modport source (output valid, op, job_id, job_priority, job_arrival, job_burst,
                    input ready);
    modport sink (input valid, op, job_id, job_priority, job_arrival, job_burst,
                  output ready);
endinterface

interface pps_out_if;
    logic        valid;
    logic        ready;
    logic        admit_ok;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        finished;
    logic [15:0] finish_time;

    modport source (output valid, admit_ok, busy_res, running_id, finished, finish_time,
                    input ready);
    modport sink (input valid, admit_ok, busy_res, running_id, finished, finish_time,
                  output ready);
endinterface

>>> design/pps_cmp.sv
// shared compare unit: is the candidate slot eligible and better than the best so far
`timescale 1ns / 1ps

module pps_cmp (
    input  pps_pkg::slot_t cand,
    input  logic           cand_used,
    input  pps_pkg::slot_t best,
    input  logic           best_vld,
    input  logic [15:0]    time_now,
    output logic           take
);

    logic eligible;
    logic better;

    assign eligible = cand_used && (cand.arrival <= time_now);
    // strict compare so the lower slot keeps a full tie
    assign better   = !best_vld
                   || (cand.prio < best.prio)
                   || ((cand.prio == best.prio) && (cand.id < best.id));
    assign take     = eligible && better;

endmodule

>>> design/pps_core.sv
// slot table, sequencer and time counter of the scheduler
`timescale 1ns / 1ps

module pps_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pps_pkg::item_t  in_item,
    output logic            res_vld,
    input  logic            res_ready,
    output pps_pkg::res_t   res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADMIT = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]                state_reg, state_next;
    pps_pkg::slot_cnt_t        cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    pps_pkg::slot_idx_t        rd_idx_reg, rd_idx_next;
    pps_pkg::slot_t            rdata_reg;
    pps_pkg::slot_t            best_reg, best_next;
    logic                      best_vld_reg, best_vld_next;
    pps_pkg::slot_idx_t        best_idx_reg, best_idx_next;
    pps_pkg::item_t            item_reg, item_next;
    logic [15:0]               time_now_reg, time_now_next;
    logic [pps_pkg::SLOTS-1:0] used_reg, used_next;

    pps_pkg::slot_t            mem [pps_pkg::SLOTS];
    logic                      wr_en;
    pps_pkg::slot_idx_t        wr_idx;
    pps_pkg::slot_t            wr_data;
    pps_pkg::slot_idx_t        rd_addr;

    logic                      take;
    logic [15:0]               time_adv;
    logic [15:0]               rem_dec;
    pps_pkg::slot_idx_t        cnt_idx;

    assign cnt_idx  = cnt_reg[pps_pkg::SLOT_W-1:0];
    assign rd_addr  = cnt_idx;
    assign time_adv = (time_now_reg < pps_pkg::TIME_MAX) ? time_now_reg + 16'd1
                                                         : time_now_reg;
    assign rem_dec  = (best_reg.remaining != 16'd0) ? best_reg.remaining - 16'd1
                                                    : 16'd0;

    pps_cmp u_cmp (
        .cand      (rdata_reg),
        .cand_used (used_reg[rd_idx_reg]),
        .best      (best_reg),
        .best_vld  (best_vld_reg),
        .time_now  (time_now_reg),
        .take      (take)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = rd_vld_reg;
        rd_idx_next   = rd_idx_reg;
        best_next     = best_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        item_next     = item_reg;
        time_now_next = time_now_reg;
        used_next     = used_reg;
        in_ready      = 1'b0;
        res_vld       = 1'b0;
        res           = '0;
        wr_en         = 1'b0;
        wr_idx        = cnt_idx;
        wr_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                    // a zero burst is served as one unit
                    if (in_item.job_burst == 16'd0)
                    begin
                        item_next.job_burst = 16'd1;
                    end
                    cnt_next      = '0;
                    rd_vld_next   = 1'b0;
                    best_vld_next = 1'b0;
                    state_next    = (in_item.op == pps_pkg::OP_ADMIT) ? S_ADMIT : S_SCAN;
                end
            end
            S_ADMIT:
            begin
                if (!used_reg[cnt_idx])
                begin
                    if (res_ready)
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = cnt_idx;
                        wr_data   = '{id:        item_reg.job_id,
                                      prio:      item_reg.job_priority,
                                      arrival:   item_reg.job_arrival,
                                      remaining: item_reg.job_burst};
                        used_next[cnt_idx] = 1'b1;
                        res_vld          = 1'b1;
                        res.admit_ok     = 1'b1;
                        res.finish_time  = time_now_reg;
                        state_next       = S_IDLE;
                    end
                end
                else if (cnt_reg == pps_pkg::CNT_W'(pps_pkg::SLOTS - 1))
                begin
                    // table full
                    if (res_ready)
                    begin
                        res_vld         = 1'b1;
                        res.finish_time = time_now_reg;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                // read issued in the cycle before its compare
                rd_vld_next = (cnt_reg < pps_pkg::CNT_W'(pps_pkg::SLOTS));
                rd_idx_next = cnt_idx;
                if (rd_vld_next)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_vld_reg && take)
                begin
                    best_next     = rdata_reg;
                    best_idx_next = rd_idx_reg;
                    best_vld_next = 1'b1;
                end
                if (rd_vld_reg && (cnt_reg == pps_pkg::CNT_W'(pps_pkg::SLOTS)))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (res_ready)
                begin
                    time_now_next   = time_adv;
                    res_vld         = 1'b1;
                    res.finish_time = time_adv;
                    if (best_vld_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_idx            = best_idx_reg;
                        wr_data           = best_reg;
                        wr_data.remaining = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            used_next[best_idx_reg] = 1'b0;
                        end
                        res.busy_res   = 1'b1;
                        res.running_id = best_reg.id;
                        res.finished   = (rem_dec == 16'd0);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            time_now_reg <= '0;
            used_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            best_vld_reg <= best_vld_next;
            time_now_reg <= time_now_next;
            used_reg     <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        item_reg     <= item_next;
    end

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |-> res_ready)
        else $error("result produced with no room in output register");

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld && res.finished) |-> (res.busy_res && !res.admit_ok))
        else $error("finish reported without a running job");

    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> (time_now_reg == $past(time_now_reg)))
        else $error("time counter moved outside a tick");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= pps_pkg::CNT_W'(pps_pkg::SLOTS)))
        else $error("scan counter ran past the table");

    a_admit_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld && res.admit_ok) |=> used_reg[$past(cnt_idx)])
        else $error("admitted slot not marked used");

endmodule

>>> design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level with a registered result beat.
//
// Channels: jobs carries one beat per item, op selecting a time tick or the
// admit of a job (id, priority, arrival tick, burst). results returns one
// beat per job beat, in order. Both use valid/ready; a beat moves on an edge
// where both are high.
// Admit: the slot table's used bits are walked one slot a cycle from slot 0
// until a free one is found; a full table gives admit_ok low.
// Tick: every slot is read from the table memory and passed through the one
// compare unit, one slot a cycle, then the chosen job is charged one unit.
// The time counter stops at its maximum.
// The next job beat is taken while a result still waits in the output
// register. When results stalls, the finishing step holds until the
// register frees up, so nothing is lost or doubled.
// Reset clears the used bits and the time counter; the table is empty and
// jobs is ready right after reset.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    pps_in_if.sink    jobs,
    pps_out_if.source results
);

    pps_pkg::item_t in_item;
    pps_pkg::res_t  res;
    pps_pkg::res_t  out_data_reg;
    logic           out_vld_reg, out_vld_next;
    logic           res_vld;
    logic           res_ready;
    logic           in_ready;

    assign in_item = '{op:           jobs.op,
                       job_id:       jobs.job_id,
                       job_priority: jobs.job_priority,
                       job_arrival:  jobs.job_arrival,
                       job_burst:    jobs.job_burst};

    assign jobs.ready = in_ready;
    assign res_ready  = !out_vld_reg || results.ready;

    pps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (jobs.valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_vld   (res_vld),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_vld)
        begin
            out_vld_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.admit_ok    = out_data_reg.admit_ok;
    assign results.busy_res    = out_data_reg.busy_res;
    assign results.running_id  = out_data_reg.running_id;
    assign results.finished    = out_data_reg.finished;
    assign results.finish_time = out_data_reg.finish_time;

endmodule

>>> bench/tb_preemptive_priority_scheduler.sv
// self-checking bench for the preemptive priority scheduler with a behavioral job table
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;

    localparam int RUN_LIMIT = 5_000_000;

    logic clk;
    logic rst_n;

    pps_in_if  jobs ();
    pps_out_if results ();

    preemptive_priority_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (jobs),
        .results (results)
    );

    // behavioral job table
    logic        tbl_used [pps_pkg::SLOTS];
    logic [7:0]  tbl_id   [pps_pkg::SLOTS];
    logic [7:0]  tbl_prio [pps_pkg::SLOTS];
    logic [15:0] tbl_arr  [pps_pkg::SLOTS];
    logic [15:0] tbl_left [pps_pkg::SLOTS];
    logic [15:0] clock_now;

    pps_pkg::item_t job_q[$];
    pps_pkg::res_t  due_results[$];

    int  cyc = 0;
    int  acc_cnt = 0;
    int  err_cnt = 0;
    int  send_gap = 0;
    int  rdy_gap = 0;
    int  plan_time = 0;
    bit  in_beat = 0;
    bit  out_beat = 0;
    bit  fast = 0;
    bit  hold_off = 0;

    function automatic pps_pkg::res_t schedule_item(pps_pkg::item_t it);
        pps_pkg::res_t r;
        int            pick;
        r = '0;
        pick = -1;
        if (it.op == pps_pkg::OP_ADMIT)
        begin
            for (int s = 0; s < pps_pkg::SLOTS; s++)
                if (pick < 0 && !tbl_used[s])
                    pick = s;
            if (pick >= 0)
            begin
                tbl_used[pick] = 1'b1;
                tbl_id[pick]   = it.job_id;
                tbl_prio[pick] = it.job_priority;
                tbl_arr[pick]  = it.job_arrival;
                tbl_left[pick] = (it.job_burst == 16'd0) ? 16'd1 : it.job_burst;
                r.admit_ok = 1'b1;
            end
        end
        else
        begin
            for (int s = 0; s < pps_pkg::SLOTS; s++)
            begin
                if (tbl_used[s] && tbl_arr[s] <= clock_now)
                begin
                    if (pick < 0 || tbl_prio[s] < tbl_prio[pick] ||
                        (tbl_prio[s] == tbl_prio[pick] && tbl_id[s] < tbl_id[pick]))
                        pick = s;
                end
            end
            if (clock_now != pps_pkg::TIME_MAX)
                clock_now = clock_now + 16'd1;
            if (pick >= 0)
            begin
                if (tbl_left[pick] != 16'd0)
                    tbl_left[pick] = tbl_left[pick] - 16'd1;
                r.busy_res   = 1'b1;
                r.running_id = tbl_id[pick];
                if (tbl_left[pick] == 16'd0)
                begin
                    r.finished     = 1'b1;
                    tbl_used[pick] = 1'b0;
                end
            end
        end
        r.finish_time = clock_now;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (fast || (cyc % 4096) >= 3072)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic pps_pkg::item_t job_beat(logic op, int id, int prio, int arr, int burst);
        pps_pkg::item_t it;
        it.op           = op;
        it.job_id       = 8'(id);
        it.job_priority = 8'(prio);
        it.job_arrival  = 16'(arr);
        it.job_burst    = 16'(burst);
        return it;
    endfunction

    task automatic queue_job(pps_pkg::item_t it);
        job_q.push_back(it);
        if (it.op == pps_pkg::OP_TICK && plan_time < 65535)
            plan_time++;
    endtask

    task automatic drain();
        while (job_q.size() != 0 || jobs.valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        for (int s = 0; s < pps_pkg::SLOTS; s++)
            tbl_used[s] = 1'b0;
        clock_now = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // accept side: every job beat taken by the block updates the table
    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= RUN_LIMIT)
        begin
            $display("tb_preemptive_priority_scheduler: errors");
            $finish;
        end
        in_beat = jobs.valid && jobs.ready;
        if (in_beat)
        begin
            acc_cnt++;
            due_results.push_back(schedule_item('{jobs.op, jobs.job_id, jobs.job_priority,
                                                  jobs.job_arrival, jobs.job_burst}));
        end
    end

    // result checker
    always @(posedge clk)
    begin : mon
        pps_pkg::res_t want;
        out_beat = results.valid && results.ready;
        if (out_beat)
        begin
            if (due_results.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("unexpected result beat at cycle %0d", cyc);
                err_cnt++;
            end
            else
            begin
                want = due_results.pop_front();
                if (results.admit_ok !== want.admit_ok ||
                    results.busy_res !== want.busy_res ||
                    results.running_id !== want.running_id ||
                    results.finished !== want.finished ||
                    results.finish_time !== want.finish_time)
                begin
                    if (err_cnt < 10)
                    begin
                        $write("mismatch cycle %0d: exp ok=%0d busy=%0d id=%0d fin=%0d t=%0d, ",
                               cyc, want.admit_ok, want.busy_res, want.running_id,
                               want.finished, want.finish_time);
                        $display("got ok=%0d busy=%0d id=%0d fin=%0d t=%0d",
                                 results.admit_ok, results.busy_res, results.running_id,
                                 results.finished, results.finish_time);
                    end
                    err_cnt++;
                end
            end
        end
    end

    // job beat driver
    always @(negedge clk)
    begin : drv
        pps_pkg::item_t nxt;
        if (!rst_n)
        begin
            jobs.valid        <= 1'b0;
            jobs.op           <= pps_pkg::OP_TICK;
            jobs.job_id       <= '0;
            jobs.job_priority <= '0;
            jobs.job_arrival  <= '0;
            jobs.job_burst    <= '0;
        end
        else if (!jobs.valid || in_beat)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                jobs.valid <= 1'b0;
            end
            else if (job_q.size() > 0)
            begin
                nxt = job_q.pop_front();
                jobs.op           <= nxt.op;
                jobs.job_id       <= nxt.job_id;
                jobs.job_priority <= nxt.job_priority;
                jobs.job_arrival  <= nxt.job_arrival;
                jobs.job_burst    <= nxt.job_burst;
                jobs.valid        <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                jobs.valid <= 1'b0;
            end
        end
    end

    // result ready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (out_beat)
                rdy_gap = pick_gap();
            if (hold_off)
                results.ready <= 1'b0;
            else if (rdy_gap > 0)
            begin
                rdy_gap--;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    // long back-pressure window so the block backs up onto its input
    initial
    begin
        while (acc_cnt < 300)
            @(negedge clk);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        pps_pkg::item_t it;
        int             seg_left;
        int             admit_pct;
        int             parked;
        int             r;
        int             arr;
        int             burst;

        seg_left = 0;
        admit_pct = 35;
        parked = 0;

        // directed: idle tick, extremes, zero burst, ties, late arrival, full table
        queue_job(job_beat(pps_pkg::OP_TICK, 0, 0, 0, 0));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 0, 0, 0, 1));
        queue_job(job_beat(pps_pkg::OP_TICK, 0, 0, 0, 0));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 255, 255, 65535, 65535));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 7, 4, 0, 0));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 3, 4, 0, 2));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 3, 4, 0, 2));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 1, 2, 6, 1));
        repeat (4) queue_job(job_beat(pps_pkg::OP_TICK, 0, 0, 0, 0));
        for (int k = 0; k < 14; k++)
            queue_job(job_beat(pps_pkg::OP_ADMIT, 16 + k, 128, 0, 1));

        // random: segments lean toward filling or draining the table
        for (int n = 0; n < 900; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                r = $urandom_range(0, 2);
                admit_pct = (r == 0) ? 10 : (r == 1) ? 35 : 65;
            end
            seg_left--;
            it.op = ($urandom_range(0, 99) < admit_pct) ? pps_pkg::OP_ADMIT : pps_pkg::OP_TICK;
            it.job_id = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                             : 8'($urandom_range(0, 255));
            it.job_priority = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3))
                                                         : 8'($urandom_range(0, 255));
            burst = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 20);
            r = $urandom_range(0, 99);
            if (r < 2 && parked < 6)
            begin
                // far-future job with a long burst, stays parked in its slot
                arr = $urandom_range(40000, 65535);
                burst = $urandom_range(1, 65535);
                if (it.op == pps_pkg::OP_ADMIT)
                    parked++;
            end
            else if (r < 70)
            begin
                arr = plan_time + $urandom_range(0, 12);
                if (arr > 65535)
                    arr = 65535;
            end
            else
            begin
                arr = $urandom_range(0, plan_time);
            end
            it.job_arrival = 16'(arr);
            it.job_burst = 16'(burst);
            queue_job(it);
        end

        drain();

        // equal id and priority plus a zero burst with both sides always ready
        fast = 1'b1;
        queue_job(job_beat(pps_pkg::OP_ADMIT, 2, 0, 0, 2));
        queue_job(job_beat(pps_pkg::OP_ADMIT, 2, 0, 0, 0));
        repeat (6) queue_job(job_beat(pps_pkg::OP_TICK, 0, 0, 0, 0));

        drain();
        repeat (40) @(posedge clk);
        if (err_cnt == 0 && due_results.size() == 0)
            $display("tb_preemptive_priority_scheduler: clean");
        else
            $display("tb_preemptive_priority_scheduler: errors");
        $finish;
    end

endmodule
